// ----- hdl/tsq_pkg.sv -----
package tsq_pkg;

    localparam int DEPTH_DEF  = 256;
    localparam int DATA_W_DEF = 32;
    localparam int PUSH_W     = 32;
    localparam int POP_W      = 32;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // front to back command handshake (data travels beside it)
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_cmd_ctl;

endpackage

// ----- hdl/tsq_front.sv -----
module tsq_front #(
    parameter int DATA_WIDTH = tsq_pkg::DATA_W_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_mode,
    input  logic signed [tsq_pkg::PUSH_W-1:0] i_push_value,
    output tsq_pkg::t_cmd_ctl            o_cmd,
    output logic [DATA_WIDTH-1:0]        o_cmd_data,
    input  logic                         i_cmd_ready
);

    // two-entry command queue
    logic [1:0]            r_cnt;
    logic                  r_wr_ptr;
    logic                  r_rd_ptr;
    tsq_pkg::t_op          r_op   [2];
    logic [DATA_WIDTH-1:0] r_data [2];

    logic                  push;
    logic                  pop;
    tsq_pkg::t_op          in_op;
    logic [DATA_WIDTH+tsq_pkg::PUSH_W-1:0] in_wide;
    logic [DATA_WIDTH-1:0] in_data;

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign pop     = o_cmd.valid && i_cmd_ready;

    // only bit 0 of mode matters; value is fitted to the storage width
    assign in_op   = i_mode ? tsq_pkg::OP_DEQ : tsq_pkg::OP_ENQ;
    assign in_wide = {{DATA_WIDTH{1'b0}}, i_push_value};
    assign in_data = in_wide[DATA_WIDTH-1:0];

    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.op    = r_op[r_rd_ptr];
    assign o_cmd_data  = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_op[r_wr_ptr]   <= in_op;
            r_data[r_wr_ptr] <= in_data;
        end
    end

    property p_cnt_range;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3;
    endproperty
    a_cnt_range: assert property (p_cnt_range) else $error("queue count out of range");

    property p_ptrs_match;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wr_ptr == r_rd_ptr);
    endproperty
    a_ptrs_match: assert property (p_ptrs_match) else $error("queue pointers disagree");

    property p_cnt_step;
        @(posedge i_clk) disable iff (!i_rst_n)
            (push && !pop) |=> (r_cnt == $past(r_cnt) + 2'd1);
    endproperty
    a_cnt_step: assert property (p_cnt_step) else $error("queue count missed a push");

endmodule

// ----- hdl/tsq_back.sv -----
module tsq_back #(
    parameter int DEPTH      = tsq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = tsq_pkg::DATA_W_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tsq_pkg::t_cmd_ctl                i_cmd,
    input  logic [DATA_WIDTH-1:0]            i_cmd_data,
    output logic                             o_cmd_ready,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [tsq_pkg::POP_W-1:0] o_pop_value,
    output logic [1:0]                       o_status
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MOVE = 3'b010,
        S_POP  = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_in_count, n_in_count;
    logic [CNT_W-1:0]           r_out_count, n_out_count;
    logic                       r_mv_pend, n_mv_pend;

    logic [DATA_WIDTH-1:0]      r_in_mem  [DEPTH];
    logic [DATA_WIDTH-1:0]      r_out_mem [DEPTH];
    logic [DATA_WIDTH-1:0]      r_in_rd;
    logic [DATA_WIDTH-1:0]      r_out_rd;

    logic                       r_out_valid;
    logic [tsq_pkg::POP_W-1:0]  r_out_value;
    tsq_pkg::t_status           r_out_status;

    logic                       in_we, in_re, out_we, out_re;
    logic                       load;
    logic [tsq_pkg::POP_W-1:0]  ld_value;
    tsq_pkg::t_status           ld_status;
    logic                       out_free;
    logic                       in_full, in_empty, out_empty;
    logic [CNT_W-1:0]           in_dec, out_dec;
    logic [DATA_WIDTH+tsq_pkg::POP_W-1:0] rd_wide, none_wide;
    logic [CNT_W:0]             moved_total;

    assign out_free  = !r_out_valid || i_ready;
    assign in_full   = (r_in_count == CNT_W'(DEPTH));
    assign in_empty  = (r_in_count == '0);
    assign out_empty = (r_out_count == '0);
    assign in_dec    = r_in_count - CNT_W'(1);
    assign out_dec   = r_out_count - CNT_W'(1);

    // stored words map onto the 32-bit result by zero-extend or truncate
    assign rd_wide   = {{tsq_pkg::POP_W{1'b0}}, r_out_rd};
    assign none_wide = {{tsq_pkg::POP_W{1'b0}}, {DATA_WIDTH{1'b1}}};

    assign moved_total = {1'b0, r_in_count} + {1'b0, r_out_count}
                       + (CNT_W + 1)'(r_mv_pend);

    always_comb begin
        n_state     = r_state;
        n_in_count  = r_in_count;
        n_out_count = r_out_count;
        n_mv_pend   = 1'b0;
        in_we       = 1'b0;
        in_re       = 1'b0;
        out_we      = 1'b0;
        out_re      = 1'b0;
        load        = 1'b0;
        ld_value    = '0;
        ld_status   = tsq_pkg::ST_OK;
        o_cmd_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = out_free;
                if (i_cmd.valid && out_free) begin
                    if (i_cmd.op == tsq_pkg::OP_ENQ) begin
                        load = 1'b1;
                        if (in_full) begin
                            ld_status = tsq_pkg::ST_FULL;
                        end else begin
                            in_we      = 1'b1;
                            n_in_count = r_in_count + CNT_W'(1);
                        end
                    end else if (in_empty && out_empty) begin
                        load      = 1'b1;
                        ld_value  = none_wide[tsq_pkg::POP_W-1:0];
                        ld_status = tsq_pkg::ST_EMPTY;
                    end else if (!out_empty) begin
                        out_re      = 1'b1;
                        n_out_count = out_dec;
                        n_state     = S_POP;
                    end else begin
                        n_state = S_MOVE;
                    end
                end
            end
            S_MOVE: begin
                // read top of input stack, write it to output stack next cycle
                if (r_mv_pend) begin
                    out_we      = 1'b1;
                    n_out_count = r_out_count + CNT_W'(1);
                end
                if (!in_empty) begin
                    in_re      = 1'b1;
                    n_in_count = in_dec;
                    n_mv_pend  = 1'b1;
                end else if (!r_mv_pend) begin
                    out_re      = 1'b1;
                    n_out_count = out_dec;
                    n_state     = S_POP;
                end
            end
            S_POP: begin
                load     = 1'b1;
                ld_value = rd_wide[tsq_pkg::POP_W-1:0];
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_count  <= '0;
            r_out_count <= '0;
            r_mv_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_count  <= n_in_count;
            r_out_count <= n_out_count;
            r_mv_pend   <= n_mv_pend;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_value  <= ld_value;
            r_out_status <= ld_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_we) begin
            r_in_mem[r_in_count[ADDR_W-1:0]] <= i_cmd_data;
        end
        if (in_re) begin
            r_in_rd <= r_in_mem[in_dec[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_we) begin
            r_out_mem[r_out_count[ADDR_W-1:0]] <= r_in_rd;
        end
        if (out_re) begin
            r_out_rd <= r_out_mem[out_dec[ADDR_W-1:0]];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pop_value = r_out_value;
    assign o_status    = r_out_status;

    property p_cnt_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_in_count <= CNT_W'(DEPTH)) && (r_out_count <= CNT_W'(DEPTH));
    endproperty
    a_cnt_bound: assert property (p_cnt_bound) else $error("stack count above depth");

    property p_pop_slot_free;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state == S_POP) |-> !r_out_valid;
    endproperty
    a_pop_slot_free: assert property (p_pop_slot_free) else $error("pop with result pending");

    property p_move_conserves;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_MOVE && n_state == S_MOVE) |=> (moved_total == $past(moved_total));
    endproperty
    a_move_conserves: assert property (p_move_conserves) else $error("refill lost a word");

endmodule

// ----- hdl/two_stack_queue.sv -----
// FIFO queue built from two LIFO stacks of DEPTH words each, kept in two
// single-port-style memories. Each input word is an enqueue (mode 0) or a
// dequeue (mode 1) and yields exactly one result word: 0 with status 0 for
// an accepted enqueue, the dequeued value with status 0, -1 with status 1
// for a dequeue of an empty queue, or 0 with status 2 when an enqueue finds
// the input stack full (the word is dropped, even if the output stack has
// room). A two-entry command queue decouples the input handshake from the
// stack sequencer. The sequencer answers an enqueue or an empty/full case
// from its idle state; a dequeue served from the output stack also passes
// through a pop state, set by the output stack's registered read port. A
// dequeue that finds the output stack empty first copies all N words of the
// input stack across, one per cycle through the input stack's read port.
module two_stack_queue #(
    parameter int DEPTH      = tsq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = tsq_pkg::DATA_W_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_mode,
    input  logic signed [tsq_pkg::PUSH_W-1:0] i_push_value,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [tsq_pkg::POP_W-1:0] o_pop_value,
    output logic [1:0]                       o_status
);

    tsq_pkg::t_cmd_ctl      cmd;
    logic [DATA_WIDTH-1:0]  cmd_data;
    logic                   cmd_ready;

    tsq_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .o_cmd        (cmd),
        .o_cmd_data   (cmd_data),
        .i_cmd_ready  (cmd_ready)
    );

    tsq_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_data  (cmd_data),
        .o_cmd_ready (cmd_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pop_value (o_pop_value),
        .o_status    (o_status)
    );

endmodule

// ----- bench/tb_two_stack_queue.sv -----
module tb_two_stack_queue;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = tsq_pkg::DEPTH_DEF;
    localparam int DATA_W    = tsq_pkg::DATA_W_DEF;
    localparam int LIMIT     = 300000;
    localparam int HOLD_LEN  = 700;
    localparam int HOLD_AT   = 120;
    localparam int TAIL_LEN  = 60;
    localparam int SETTLE    = DEPTH + 20;

    typedef struct packed {
        logic [tsq_pkg::POP_W-1:0] pop;
        tsq_pkg::t_status          status;
    } t_qresult;

    typedef struct {
        tsq_pkg::t_op               op;
        logic [tsq_pkg::PUSH_W-1:0] value;
        bit                         wait_drain;
    } t_qword;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_ready;
    logic                              i_mode = 1'b0;
    logic signed [tsq_pkg::PUSH_W-1:0] i_push_value = '0;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic signed [tsq_pkg::POP_W-1:0]  o_pop_value;
    logic [1:0]                        o_status;

    two_stack_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow copy of the two stacks
    logic [DATA_W-1:0] shadow_in_stk  [DEPTH];
    logic [DATA_W-1:0] shadow_out_stk [DEPTH];
    int                shadow_in_cnt = 0;
    int                shadow_out_cnt = 0;

    t_qword   pending_words[$];
    t_qresult expected_results[$];

    int  cycles = 0;
    int  words_in = 0;
    int  results_out = 0;
    int  mismatches = 0;
    int  full_drops = 0;
    int  empty_deqs = 0;
    int  peak_fill = 0;
    bit  word_taken = 1'b0;
    bit  tail_phase = 1'b0;
    int  send_gap = 0;
    int  recv_stall = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    function automatic t_qresult apply_queue_op(input tsq_pkg::t_op op,
                                                input logic [DATA_W-1:0] v);
        t_qresult r;
        r.pop = '0;
        r.status = tsq_pkg::ST_OK;
        if (op == tsq_pkg::OP_ENQ) begin
            if (shadow_in_cnt >= DEPTH) begin
                r.status = tsq_pkg::ST_FULL;
            end else begin
                shadow_in_stk[shadow_in_cnt] = v;
                shadow_in_cnt++;
            end
        end else if (shadow_in_cnt == 0 && shadow_out_cnt == 0) begin
            r.pop = '1;
            r.status = tsq_pkg::ST_EMPTY;
        end else begin
            // output stack dry: move the whole input stack over, top first
            if (shadow_out_cnt == 0) begin
                while (shadow_in_cnt > 0 && shadow_out_cnt < DEPTH) begin
                    shadow_in_cnt--;
                    shadow_out_stk[shadow_out_cnt] = shadow_in_stk[shadow_in_cnt];
                    shadow_out_cnt++;
                end
            end
            shadow_out_cnt--;
            r.pop = shadow_out_stk[shadow_out_cnt];
        end
        return r;
    endfunction

    function automatic logic [tsq_pkg::PUSH_W-1:0] rand_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '1;
            3: return '0;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_word(input tsq_pkg::t_op op, input logic [tsq_pkg::PUSH_W-1:0] v,
                            input bit drain = 1'b0);
        t_qword w;
        w.op = op;
        w.value = v;
        w.wait_drain = drain;
        pending_words = {pending_words, w};
    endtask

    task automatic add_mix(input int count, input int deq_pct);
        for (int k = 0; k < count; k++) begin
            add_word(($urandom_range(99) < deq_pct) ? tsq_pkg::OP_DEQ : tsq_pkg::OP_ENQ,
                     rand_value());
        end
    endtask

    // handshakes and result checking, all sampled at the rising edge
    always @(posedge i_clk) begin : watch_ports
        t_qresult want;
        cycles++;
        word_taken = i_rst_n && i_valid && o_ready;
        if (word_taken) begin
            want = apply_queue_op(tsq_pkg::t_op'(i_mode), i_push_value);
            expected_results = {expected_results, want};
            words_in++;
            if (want.status == tsq_pkg::ST_FULL) full_drops++;
            if (want.status == tsq_pkg::ST_EMPTY) empty_deqs++;
            if (shadow_in_cnt + shadow_out_cnt > peak_fill)
                peak_fill = shadow_in_cnt + shadow_out_cnt;
        end
        if (i_rst_n && o_valid && i_ready) begin
            results_out++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: pop %h status %0d", o_pop_value, o_status);
            end else begin
                want = expected_results.pop_front();
                if (o_pop_value !== want.pop || o_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: pop %h status %0d, expected pop %h status %0d",
                                 results_out, o_pop_value, o_status, want.pop, want.status);
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // sender: one NBA per signal per falling edge
    always @(negedge i_clk) begin : drive_words
        logic                       nxt_valid;
        logic                       nxt_mode;
        logic [tsq_pkg::PUSH_W-1:0] nxt_val;
        t_qword                     w;
        nxt_valid = i_valid;
        nxt_mode  = i_mode;
        nxt_val   = i_push_value;
        if (i_rst_n) begin
            if (i_valid && word_taken) begin
                nxt_valid = 1'b0;
                if (!tail_phase && $urandom_range(99) < 10) send_gap = $urandom_range(1, 19);
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_words.size() > 0 &&
                             !(pending_words[0].wait_drain && expected_results.size() > 0)) begin
                    w = pending_words.pop_front();
                    nxt_valid = 1'b1;
                    nxt_mode  = w.op;
                    nxt_val   = w.value;
                end
            end
            tail_phase = (pending_words.size() < TAIL_LEN);
        end
        i_valid      <= nxt_valid;
        i_mode       <= nxt_mode;
        i_push_value <= nxt_val;
    end

    // receiver: random stall bursts plus one long hold-off while words keep coming
    always @(negedge i_clk) begin : drive_ready
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (i_rst_n) begin
            if (!hold_done && words_in >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                nxt_ready = 1'b0;
            end else if (!tail_phase && $urandom_range(99) < 8) begin
                recv_stall = $urandom_range(1, 19) - 1;
                nxt_ready = 1'b0;
            end
        end
        i_ready <= nxt_ready;
    end

    initial begin
        // directed: empty dequeue, extreme values, refill with words left behind
        add_word(tsq_pkg::OP_DEQ, '0);
        add_word(tsq_pkg::OP_ENQ, 32'h7fff_ffff);
        add_word(tsq_pkg::OP_ENQ, 32'h8000_0000);
        add_word(tsq_pkg::OP_ENQ, '0);
        add_word(tsq_pkg::OP_ENQ, '1);
        add_word(tsq_pkg::OP_ENQ, 32'haaaa_aaaa);
        add_word(tsq_pkg::OP_ENQ, 32'h5555_5555);
        add_word(tsq_pkg::OP_ENQ, 32'h0000_0001);
        repeat (3) add_word(tsq_pkg::OP_DEQ, '1);
        add_word(tsq_pkg::OP_ENQ, 32'h1234_5678);
        repeat (4) add_word(tsq_pkg::OP_DEQ, 32'h5555_5555);
        add_word(tsq_pkg::OP_DEQ, '0);
        add_word(tsq_pkg::OP_DEQ, '1);
        add_word(tsq_pkg::OP_DEQ, 32'haaaa_aaaa);
        // overfill the input stack, then drain through a full refill
        add_mix(DEPTH + 6, 0);
        add_mix(30, 100);
        add_word(tsq_pkg::OP_DEQ, rand_value(), 1'b1);
        add_mix(200, 50);
        add_word(tsq_pkg::OP_ENQ, rand_value(), 1'b1);
        add_mix(140, 70);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_words.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("%0d words sent, %0d results checked, peak occupancy %0d of %0d",
                 words_in, results_out, peak_fill, 2 * DEPTH);
        $display("%0d dropped on full input stack, %0d dequeues on empty queue",
                 full_drops, empty_deqs);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
